// ===== rtl/kdehd_pkg.sv =====
`timescale 1ns / 1ps

package kdehd_pkg;

    localparam int NUM_DIGITS_DEF = 4;
    localparam int NUM_DIGITS_MAX = 8;

    localparam int ACC_W   = 32;
    localparam int VALUE_W = 16;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // register addresses
    localparam logic REG_SEG_INV = 1'b0;

    typedef enum logic {
        CMD_PRESS = 1'b0,
        CMD_TICK  = 1'b1
    } t_cmd;

    localparam logic [3:0] KEY_DIG1  = 4'd0;
    localparam logic [3:0] KEY_DIG9  = 4'd8;
    localparam logic [3:0] KEY_ENTER = 4'd9;
    localparam logic [3:0] KEY_ZERO  = 4'd10;

    localparam logic [7:0] ANODE_NONE = 8'hFF;
    localparam logic [7:0] SEG_BLANK  = 8'h00;

    typedef struct packed {
        logic       cmd;
        logic [3:0] key_pos;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  anode_drive;
        logic [7:0]  segment_drive;
        logic [15:0] shown_hex_value;
    } t_out_word;

    // hex font, bit 0 = segment a
    function automatic logic [7:0] hex_font(input logic [3:0] nib);
        logic [7:0] pat;
        case (nib)
            4'h0:    pat = 8'h3F;
            4'h1:    pat = 8'h06;
            4'h2:    pat = 8'h5B;
            4'h3:    pat = 8'h4F;
            4'h4:    pat = 8'h66;
            4'h5:    pat = 8'h6D;
            4'h6:    pat = 8'h7D;
            4'h7:    pat = 8'h07;
            4'h8:    pat = 8'h7F;
            4'h9:    pat = 8'h67;
            4'hA:    pat = 8'h77;
            4'hB:    pat = 8'h7C;
            4'hC:    pat = 8'h39;
            4'hD:    pat = 8'h5E;
            4'hE:    pat = 8'h79;
            4'hF:    pat = 8'h71;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

// ===== rtl/kdehd_digit_drive.sv =====
`timescale 1ns / 1ps

module kdehd_digit_drive #(
    parameter int NUM_DIGITS = kdehd_pkg::NUM_DIGITS_DEF,
    parameter int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1
) (
    input  logic [IDX_W-1:0]               i_idx,
    input  logic [kdehd_pkg::VALUE_W-1:0]  i_value,
    input  logic                           i_invert,
    output logic [7:0]                     o_anode,
    output logic [7:0]                     o_segment
);
    import kdehd_pkg::*;

    localparam logic [3:0] LAST_DIGIT = 4'(NUM_DIGITS - 1);

    logic [3:0]  nsel;
    logic [31:0] shifted;
    logic [7:0]  pattern;

    always_comb begin
        // digit 0 carries the most significant nibble
        nsel      = LAST_DIGIT - 4'(i_idx);
        shifted   = 32'(i_value) >> {nsel[2:0], 2'b00};
        pattern   = hex_font(shifted[3:0]);
        o_segment = i_invert ? ~pattern : pattern;
        o_anode   = ~(8'b1 << i_idx);
    end

endmodule

// ===== rtl/keypad_decimal_entry_hex_display.sv =====
`timescale 1ns / 1ps

// Keypad decimal entry with multiplexed hex seven-segment display.
// Input channel (i_in_valid / o_in_ready / i_in_word): each word is either a
// keypad press (cmd 0, key_pos 0-8 digits 1-9, 9 enter, 10 digit 0, others
// ignored) or a display refresh tick (cmd 1).
// Output channel (o_out_valid / i_out_ready / o_out_word): exactly one word
// per input word. A press returns anode 0xFF, segments 0 and the shown value;
// a tick returns the anode/segment drive of the current digit, then advances.
// State updates and the result register load at the accepting edge.
// Throughput is one word per cycle while the receiver does not stall, set by
// the single output register, refilled in the same cycle it is drained.
// When the receiver stalls, the held word waits and o_in_ready drops until
// it is taken.
// Reset clears the accumulator, the shown value, the digit counter, the
// segment polarity register and the output valid flag.
// APB register 0 (address 0): bit 0 inverts segments for common anode parts;
// write only while idle.
module keypad_decimal_entry_hex_display #(
    parameter int NUM_DIGITS = kdehd_pkg::NUM_DIGITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  kdehd_pkg::t_in_word            i_in_word,

    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output kdehd_pkg::t_out_word           o_out_word,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kdehd_pkg::APB_AW-1:0]   paddr,
    input  logic [kdehd_pkg::APB_DW-1:0]   pwdata,
    output logic [kdehd_pkg::APB_DW-1:0]   prdata,
    output logic                           pready
);
    import kdehd_pkg::*;

    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_DIGITS - 1);

    logic [ACC_W-1:0]   r_acc,       n_acc;
    logic [VALUE_W-1:0] r_value,     n_value;
    logic [IDX_W-1:0]   r_idx,       n_idx;
    logic               r_seg_inv;
    logic               r_out_valid;
    t_out_word          r_out_word,  n_out_word;

    logic               accept;
    logic [3:0]         digit;
    logic [7:0]         tick_anode;
    logic [7:0]         tick_seg;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_inv <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == REG_SEG_INV) begin
            r_seg_inv <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_SEG_INV) ? {{(APB_DW-1){1'b0}}, r_seg_inv}
                                              : '0;

    // handshake
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    kdehd_digit_drive #(
        .NUM_DIGITS (NUM_DIGITS),
        .IDX_W      (IDX_W)
    ) u_digit (
        .i_idx     (r_idx),
        .i_value   (r_value),
        .i_invert  (r_seg_inv),
        .o_anode   (tick_anode),
        .o_segment (tick_seg)
    );

    always_comb begin
        n_acc      = r_acc;
        n_value    = r_value;
        n_idx      = r_idx;
        n_out_word = r_out_word;
        digit      = (i_in_word.key_pos == KEY_ZERO) ? 4'd0 : i_in_word.key_pos + 4'd1;

        if (i_in_word.cmd == CMD_PRESS) begin
            if (i_in_word.key_pos inside {[KEY_DIG1:KEY_DIG9], KEY_ZERO}) begin
                // acc * 10 + digit, wrapping
                n_acc = (r_acc << 3) + (r_acc << 1) + ACC_W'(digit);
            end else if (i_in_word.key_pos == KEY_ENTER) begin
                n_value = r_acc[VALUE_W-1:0];
                n_acc   = '0;
            end
            n_out_word.anode_drive     = ANODE_NONE;
            n_out_word.segment_drive   = SEG_BLANK;
            n_out_word.shown_hex_value = n_value;
        end else begin
            n_out_word.anode_drive     = tick_anode;
            n_out_word.segment_drive   = tick_seg;
            n_out_word.shown_hex_value = r_value;
            n_idx = (r_idx >= IDX_LAST) ? '0 : r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_value     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_acc   <= n_acc;
                r_value <= n_value;
                r_idx   <= n_idx;
            end
            if (o_in_ready) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_word <= n_out_word;
        end
    end

endmodule
